>>> rtl/ifs_pkg.sv
// ifs_pkg: shared codes and types for the identifier allocator
// request modes, status codes and the compare unit's request and result structs
// no dependencies
package ifs_pkg;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // operands are 33 bits so a carried-out candidate id compares correctly
  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

>>> rtl/id_allocator_free_stack.sv
// id_allocator_free_stack: lifo free-list identifier allocator, top level
// holds the range registers and apb port; instantiates ifs_ctrl, ifs_cmp and ifs_ram
//
//   channel   signals                                   transaction
//   --------  ----------------------------------------  -------------------------------
//   request   start, busy, mode, given_id               start high while busy low
//   result    done, result_id, status, is_live,          done high for one cycle
//             live_count, free_count
//   config    psel, penable, pwrite, paddr, pwdata,      apb access phase, pready high
//             prdata, pready
//
// allocate from the counter, clear, check of zero or of an empty stack and a free
// rejected by the upper bound: done follows the exec state; a pop and any other
// free (below the base, stack full or pushed): done follows the pop or lower state
// after exec. a check walks the stack ram one entry per cycle through the shared
// comparator to the first match or stack top. busy is low again when done is high.
// rst clears the counter and stack level; stack contents are not cleared.
// results cannot be stalled by the receiver.
module id_allocator_free_stack #(
  parameter int FREE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] given_id,
  output logic        done,
  output logic [31:0] result_id,
  output logic [1:0]  status,
  output logic        is_live,
  output logic [31:0] live_count,
  output logic [10:0] free_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ifs_pkg::*;

  localparam int AW = $clog2(FREE_DEPTH);

  logic [31:0] id_base;
  logic [31:0] id_bound;
  cmp_req_t    cmp_req;
  cmp_res_t    cmp_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  assign pready = 1'b1;

  // register 0 at byte 0, register 1 at byte 4
  always_ff @(posedge clk) begin
    if (rst) begin
      id_base  <= '0;
      id_bound <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        id_bound <= pwdata;
      end else begin
        id_base <= pwdata;
      end
    end
  end

  assign prdata = paddr[2] ? id_bound : id_base;

  ifs_ctrl #(
    .FREE_DEPTH(FREE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .given_id    (given_id),
    .id_base     (id_base),
    .id_bound    (id_bound),
    .busy        (busy),
    .done        (done),
    .result_id   (result_id),
    .status      (status),
    .is_live     (is_live),
    .live_count  (live_count),
    .free_count  (free_count),
    .cmp_req     (cmp_req),
    .cmp_res     (cmp_res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  ifs_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  ifs_ram #(
    .WIDTH (32),
    .DEPTH (FREE_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/ifs_ram.sv
// ifs_ram: generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ifs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ifs_cmp.sv
// ifs_cmp: shared 33-bit magnitude and equality compare unit
// depends on ifs_pkg for the request and result structs
module ifs_cmp (
  input  ifs_pkg::cmp_req_t req,
  output ifs_pkg::cmp_res_t res
);

  import ifs_pkg::*;

  assign res.eq = (req.a == req.b);
  assign res.lt = (req.a < req.b);

endmodule

>>> rtl/ifs_ctrl.sv
// ifs_ctrl: request sequencer, counters and result registers of the allocator
// drives the free stack ram and the shared compare unit; depends on ifs_pkg
module ifs_ctrl #(
  parameter int FREE_DEPTH = 1024,
  localparam int AW = $clog2(FREE_DEPTH),
  localparam int LW = $clog2(FREE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        mode,
  input  logic [31:0]       given_id,
  input  logic [31:0]       id_base,
  input  logic [31:0]       id_bound,
  output logic              busy,
  output logic              done,
  output logic [31:0]       result_id,
  output logic [1:0]        status,
  output logic              is_live,
  output logic [31:0]       live_count,
  output logic [10:0]       free_count,
  output ifs_pkg::cmp_req_t cmp_req,
  input  ifs_pkg::cmp_res_t cmp_res,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [31:0]       ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [31:0]       ram_rdata
);

  import ifs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_LOWER = 5'b00100,
    S_POP   = 5'b01000,
    S_WALK  = 5'b10000
  } state_t;

  localparam logic [LW-1:0] LEVEL_FULL = LW'(FREE_DEPTH);

  state_t        state, state_next;
  logic [1:0]    req_mode;
  logic [31:0]   req_id;
  logic [LW-1:0] level, level_next;
  logic [LW-1:0] walk_idx, walk_idx_next;
  logic [31:0]   issued, issued_next;
  logic          fin;
  logic [31:0]   result_id_next;
  logic [1:0]    status_next;
  logic          is_live_next;
  logic [32:0]   limit;
  logic [32:0]   cand;
  logic          id_zero;

  // a bound of zero stands for the all-ones limit
  assign limit   = {1'b0, (id_bound == '0) ? 32'hFFFF_FFFF : id_bound};
  assign cand    = {1'b0, id_base} + {1'b0, issued} + 33'd1;
  assign id_zero = (req_id == '0);

  always_comb begin
    state_next     = state;
    level_next     = level;
    issued_next    = issued;
    walk_idx_next  = walk_idx;
    fin            = 1'b0;
    result_id_next = '0;
    status_next    = ST_OK;
    is_live_next   = 1'b0;
    cmp_req.a      = {1'b0, req_id};
    cmp_req.b      = limit;
    ram_we         = 1'b0;
    ram_waddr      = level[AW-1:0];
    ram_wdata      = req_id;
    ram_raddr      = walk_idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_mode)
          MODE_ALLOC: begin
            if (level != '0) begin
              ram_raddr  = AW'(level - 1'b1);
              level_next = level - 1'b1;
              state_next = S_POP;
            end else begin
              cmp_req.a = cand;
              cmp_req.b = limit;
              fin       = 1'b1;
              if (cmp_res.lt) begin
                result_id_next = cand[31:0];
                issued_next    = issued + 32'd1;
              end else begin
                status_next = ST_EXHAUSTED;
              end
            end
          end
          MODE_FREE: begin
            // upper bound first, lower bound on the next step
            if (id_zero || !cmp_res.lt) begin
              fin         = 1'b1;
              status_next = ST_IGNORED;
            end else begin
              state_next = S_LOWER;
            end
          end
          MODE_CHECK: begin
            if (id_zero) begin
              fin = 1'b1;
            end else if (level == '0) begin
              fin          = 1'b1;
              is_live_next = 1'b1;
            end else begin
              ram_raddr     = '0;
              walk_idx_next = LW'(1);
              state_next    = S_WALK;
            end
          end
          MODE_CLEAR: begin
            level_next  = '0;
            issued_next = '0;
            fin         = 1'b1;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_LOWER: begin
        cmp_req.a = {1'b0, req_id};
        cmp_req.b = {1'b0, id_base};
        fin       = 1'b1;
        if (cmp_res.lt) begin
          status_next = ST_IGNORED;
        end else if (level == LEVEL_FULL) begin
          status_next = ST_FULL;
        end else begin
          ram_we     = 1'b1;
          level_next = level + 1'b1;
        end
      end
      S_POP: begin
        fin            = 1'b1;
        result_id_next = ram_rdata;
      end
      S_WALK: begin
        // ram_rdata holds entry walk_idx-1, read on the previous cycle
        cmp_req.a = {1'b0, ram_rdata};
        cmp_req.b = {1'b0, req_id};
        if (cmp_res.eq) begin
          fin = 1'b1;
        end else if (walk_idx == level) begin
          fin          = 1'b1;
          is_live_next = 1'b1;
        end else begin
          ram_raddr     = walk_idx[AW-1:0];
          walk_idx_next = walk_idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      level    <= '0;
      issued   <= '0;
      walk_idx <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      level    <= level_next;
      issued   <= issued_next;
      walk_idx <= walk_idx_next;
      done     <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_mode <= mode;
      req_id   <= given_id;
    end
    if (fin) begin
      result_id <= result_id_next;
      status    <= status_next;
      is_live   <= is_live_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign live_count = issued - 32'(level);
  assign free_count = 11'(level);

endmodule

>>> rtl/ifs_checker.sv
// ifs_checker: port-level assertions for the identifier allocator
// bound to id_allocator_free_stack; depends on ifs_pkg for status codes
module ifs_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] result_id,
  input logic [1:0]  status,
  input logic        is_live
);

  import ifs_pkg::*;

  // a result frees the block in the same cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result in the cycle right after acceptance");

  // failed requests never hand out an id
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_id == '0 && !is_live))
    else $error("nonzero id or live flag on a failed transaction");

  a_live_noid: assert property (@(posedge clk) disable iff (rst)
    (done && is_live) |-> (result_id == '0))
    else $error("check result carries an id");

endmodule

bind id_allocator_free_stack ifs_checker u_ifs_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result_id (result_id),
  .status    (status),
  .is_live   (is_live)
);
